// ----- src/iopbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopbr_pkg
// Shared types and constants for the I/O permission bitmap range update block.
// ----------------------------------------------------------------------------
package iopbr_pkg;

	localparam int PORT_W   = 16;
	localparam int IDX_W    = PORT_W - 3;
	localparam int LIMIT_W  = IDX_W + 1;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RANGE   = 2'd2;

	localparam logic [7:0] BYTE_ONES = 8'hff;
	localparam logic [2:0] BIT_TOP   = 3'd7;

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_CHECK  = 6'b000100,
		S_WALK   = 6'b001000,
		S_MODIFY = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic load_idx;
		logic set_present;
		logic rd;
		logic wr;
		logic next;
		logic clr;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic absent_err;
		logic range_err;
		logic in_store;
		logic at_last;
		logic full;
		logic deny;
		logic clr_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- src/io_permission_bitmap_range_update_top.sv -----
`timescale 1ns / 1ps
// flow: a rejected request goes from the check straight to the result; an accepted
//   range walks its bytes, writing whole ones and read-modify-writing partial ones
//   until the last byte or the end of the store; one request at a time, the next
//   taken once the result loads; a held result stalls the walk end
// reset: a clearing pass fills every one of the MAP_BYTES bitmap bytes with ones,
//   in_ready stays low until it ends
// ----------------------------------------------------------------------------
// io_permission_bitmap_range_update_top
// Grants or revokes an inclusive port range in a byte-packed deny bitmap.
// ----------------------------------------------------------------------------
module io_permission_bitmap_range_update_top import iopbr_pkg::*; #(
	parameter int MAP_BYTES = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [PORT_W-1:0]   first_port,
	input  logic [PORT_W-1:0]   last_port,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	iopbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iopbr_dp #(
		.MAP_BYTES (MAP_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.first_port (first_port),
		.last_port  (last_port),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status)
	);

endmodule

// ----- src/iopbr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopbr_ctrl
// Sequencer: clearing sweep after reset, request check, byte walk over the
// range with read-modify-write of partial bytes, result hand-off.
// ----------------------------------------------------------------------------
module iopbr_ctrl import iopbr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.absent_err || stat.range_err) begin
					state_d = S_DONE;
				end else begin
					cmd.set_present = !stat.deny;
					cmd.load_idx    = 1'b1;
					state_d         = S_WALK;
				end
			end
			S_WALK: begin
				if (!stat.in_store) begin
					state_d = S_DONE;
				end else if (stat.full) begin
					cmd.wr = 1'b1;
					if (stat.at_last) begin
						state_d = S_DONE;
					end else begin
						cmd.next = 1'b1;
					end
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_MODIFY;
				end
			end
			S_MODIFY: begin
				cmd.wr = 1'b1;
				if (stat.at_last) begin
					state_d = S_DONE;
				end else begin
					cmd.next = 1'b1;
					state_d  = S_WALK;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/iopbr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopbr_dp
// Datapath: request registers, byte index and masks, bitmap memory,
// map-present flag and the result register.
// ----------------------------------------------------------------------------
module iopbr_dp import iopbr_pkg::*; #(
	parameter int MAP_BYTES = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                req_type,
	input  logic [PORT_W-1:0]   first_port,
	input  logic [PORT_W-1:0]   last_port,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status
);

	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam logic [LIMIT_W-1:0] MapLimit = LIMIT_W'(MAP_BYTES);
	localparam logic [AW-1:0] ClrLast = AW'(MAP_BYTES - 1);

	logic                deny_q;
	logic [PORT_W-1:0]   first_q;
	logic [PORT_W-1:0]   last_q;
	logic [IDX_W-1:0]    idx_q;
	logic [AW-1:0]       clr_q;
	logic                present_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [7:0]          rd_q;
	logic [7:0]          mem [MAP_BYTES];

	logic [2:0] lo, hi;
	logic [7:0] mask, base, wdata;
	logic       at_first;

	assign at_first = (idx_q == first_q[PORT_W-1:3]);
	assign lo       = at_first ? first_q[2:0] : 3'd0;
	assign hi       = stat.at_last ? last_q[2:0] : BIT_TOP;
	assign mask     = (BYTE_ONES << lo) & (BYTE_ONES >> (BIT_TOP - hi));
	assign base     = stat.full ? 8'h00 : rd_q;
	assign wdata    = deny_q ? (base | mask) : (base & ~mask);

	assign stat.absent_err = deny_q && !present_q;
	assign stat.range_err  = (first_q > last_q);
	assign stat.in_store   = ({1'b0, idx_q} < MapLimit);
	assign stat.at_last    = (idx_q == last_q[PORT_W-1:3]);
	assign stat.full       = (mask == BYTE_ONES);
	assign stat.deny       = deny_q;
	assign stat.clr_done   = (clr_q == ClrLast);
	assign stat.out_free   = !out_valid_q || out_ready;

	// request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			deny_q  <= req_type;
			first_q <= first_port;
			last_q  <= last_port;
		end
		if (cmd.load_idx) begin
			idx_q <= first_q[PORT_W-1:3];
		end else if (cmd.next) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.load_out) begin
			status_q <= stat.absent_err ? ST_NOT_PRESENT :
			            stat.range_err  ? ST_BAD_RANGE   : ST_OK;
		end
	end

	// bitmap store
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_q] <= BYTE_ONES;
		end else if (cmd.wr) begin
			mem[idx_q[AW-1:0]] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			present_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr && !stat.clr_done) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.set_present) begin
				present_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

// ----- src/iopbr_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopbr_chk
// Port-level checks for the range update block, bound to the top level.
// ----------------------------------------------------------------------------
module iopbr_chk import iopbr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status
);

	// a held result keeps its status
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NOT_PRESENT ||
		               status == ST_BAD_RANGE))
		else $error("status code out of range");

	// one request in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result issued without returning to idle");

endmodule

bind io_permission_bitmap_range_update_top iopbr_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status)
);
